// ===== hdl/gbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types and constants of the bridge finder.
// ----------------------------------------------------------------------------
package gbf_pkg;
   localparam int unsigned VW = 6;
   localparam int unsigned CW = 7;
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic          operation;
      logic [VW-1:0] vertex_a;
      logic [VW-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic          has_bridge;
      logic [VW-1:0] bridge_low;
      logic [VW-1:0] bridge_high;
      logic [VW-1:0] bridge_total;
      logic          last;
   } rsp_type;
endpackage

// ===== hdl/gbf_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_req_if
// Request channel: valid, ready and an edge or finish request.
// ----------------------------------------------------------------------------
interface gbf_req_if;
   logic             valid;
   logic             ready;
   gbf_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gbf_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_rsp_if
// Response channel: valid, ready and one bridge result.
// ----------------------------------------------------------------------------
interface gbf_rsp_if;
   logic             valid;
   logic             ready;
   gbf_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/graph_bridge_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bridge_finder
// Tarjan bridge finder over an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Edge requests are taken one per cycle while the block is idle. A finish
// request runs a depth-first search under a small sequencer. Each stack step
// reads the stack top, then reads the adjacency row and vertex tables, then
// updates. A step that meets an already visited neighbor reads its discovery
// number and then enters a back-edge state that may lower the vertex's low
// value. A pass then counts the bridges, one mark row per cycle. The emit pass
// scans the mark rows in order and gives one result per bridge, or a single
// result without a bridge when there are none; it waits while a result is
// held. A clearing pass over the adjacency and mark rows follows. The same
// clearing pass also runs after reset. The block is not ready from the finish
// request until the clearing pass ends.
module graph_bridge_finder #(
   parameter int unsigned MAX_VERTICES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [6:0]          csr_write_data,
   gbf_req_if.sink             req,
   gbf_rsp_if.source           rsp
);
   localparam int unsigned NV = MAX_VERTICES;
   localparam int unsigned VW = gbf_pkg::VW;
   localparam int unsigned CW = gbf_pkg::CW;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_ROOT   = 11'b00000000010,
      S_READ   = 11'b00000000100,
      S_FETCH  = 11'b00000001000,
      S_STEP   = 11'b00000010000,
      S_BACK   = 11'b00000100000,
      S_COUNT  = 11'b00001000000,
      S_SCAN   = 11'b00010000000,
      S_EMIT   = 11'b00100000000,
      S_NONE   = 11'b01000000000,
      S_CLEAR  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] count_ff;
   logic [NV-1:0] adj_mem [NV];
   logic [NV-1:0] mark_mem [NV];
   logic [CW-1:0] disc_mem [NV];
   logic [CW-1:0] low_mem [NV];
   logic [VW-1:0] par_mem [NV];
   logic [VW-1:0] stk_v [64];
   logic [CW-1:0] stk_n [64];
   logic [NV-1:0] vis_ff;
   logic [6:0] sp_ff;
   logic [CW-1:0] clk_ff;
   logic [6:0] root_ff;
   logic [6:0] row_ff;
   logic [NV-1:0] scan_ff;
   logic [5:0] total_ff, k_ff;
   logic [VW-1:0] x_ff;
   logic [6:0] eff;
   logic [NV-1:0] mask;
   gbf_pkg::rsp_type out_ff;
   logic out_vld_ff;

   // registered reads for the step
   logic [NV-1:0] row_rd;
   logic [VW-1:0] v_rd, u_rd;
   logic [CW-1:0] n_rd;
   logic [CW-1:0] low_v, disc_u, low_u, disc_x;
   logic [VW-1:0] par_v;
   logic [NV-1:0] mrow_rd;

   assign eff = (count_ff > 7'(NV)) ? 7'(NV) : count_ff;
   always_comb begin
      for (int i = 0; i < NV; i++) mask[i] = (7'(i) < eff);
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   logic acc;
   assign acc = req.valid && req.ready;

   // candidate search over the registered row
   logic [NV-1:0] cand;
   logic          cand_any;
   logic [VW-1:0] x_sel;
   always_comb begin
      cand = '0;
      for (int i = 0; i < NV; i++)
         cand[i] = row_rd[i] && mask[i] && (n_rd < 7'(NV)) && (7'(i) >= n_rd);
      cand_any = |cand;
      x_sel = '0;
      for (int i = NV - 1; i >= 0; i--) if (cand[i]) x_sel = VW'(i);
   end

   logic [VW-1:0] mfirst;
   logic          many;
   always_comb begin
      many = |scan_ff;
      mfirst = '0;
      for (int i = NV - 1; i >= 0; i--) if (scan_ff[i]) mfirst = VW'(i);
   end

   logic out_load;
   assign out_load = ((state_ff == S_EMIT && many && k_ff != total_ff) || state_ff == S_NONE)
                     && (!out_vld_ff || rsp.ready);

   logic [VW-1:0] topi;
   assign topi = VW'(sp_ff - 7'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= 7'd64;
         vis_ff <= '0;
         out_vld_ff <= 1'b0;
         row_ff <= '0;
         sp_ff <= '0;
      end else begin
         if (csr_write_enable) count_ff <= csr_write_data;
         if (out_load) out_vld_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_vld_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  if (req.data.operation == gbf_pkg::OP_ADD) begin
                     if ({1'b0, req.data.vertex_a} < eff && {1'b0, req.data.vertex_b} < eff
                        && req.data.vertex_a != req.data.vertex_b) begin
                        adj_mem[req.data.vertex_a][req.data.vertex_b] <= 1'b1;
                        adj_mem[req.data.vertex_b][req.data.vertex_a] <= 1'b1;
                     end else if ({1'b0, req.data.vertex_a} < eff
                        && {1'b0, req.data.vertex_b} < eff) begin
                        adj_mem[req.data.vertex_a][req.data.vertex_a] <= 1'b1;
                     end
                  end else begin
                     root_ff <= '0;
                     state_ff <= S_ROOT;
                  end
               end
            end
            S_ROOT: begin
               if (root_ff >= eff) begin
                  row_ff <= '0;
                  total_ff <= '0;
                  mrow_rd <= '0;
                  state_ff <= S_COUNT;
               end else if (vis_ff[root_ff[VW-1:0]]) begin
                  root_ff <= root_ff + 7'd1;
               end else begin
                  vis_ff[root_ff[VW-1:0]] <= 1'b1;
                  disc_mem[root_ff[VW-1:0]] <= 7'd1;
                  low_mem[root_ff[VW-1:0]] <= 7'd1;
                  stk_v[0] <= root_ff[VW-1:0];
                  stk_n[0] <= '0;
                  clk_ff <= 7'd1;
                  sp_ff <= 7'd1;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               v_rd <= stk_v[topi];
               n_rd <= stk_n[topi];
               u_rd <= stk_v[VW'(sp_ff - 7'd2)];
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               row_rd <= adj_mem[v_rd];
               low_v  <= low_mem[v_rd];
               par_v  <= par_mem[v_rd];
               disc_u <= disc_mem[u_rd];
               low_u  <= low_mem[u_rd];
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (cand_any) begin
                  stk_n[topi] <= CW'({1'b0, x_sel} + 7'd1);
                  if (!vis_ff[x_sel]) begin
                     par_mem[x_sel] <= v_rd;
                     if (sp_ff < 7'd64) begin
                        vis_ff[x_sel] <= 1'b1;
                        disc_mem[x_sel] <= clk_ff + 7'd1;
                        low_mem[x_sel] <= clk_ff + 7'd1;
                        clk_ff <= clk_ff + 7'd1;
                        stk_v[sp_ff[VW-1:0]] <= x_sel;
                        stk_n[sp_ff[VW-1:0]] <= '0;
                        sp_ff <= sp_ff + 7'd1;
                     end
                     state_ff <= S_READ;
                  end else begin
                     x_ff <= x_sel;
                     disc_x <= disc_mem[x_sel];
                     state_ff <= S_BACK;
                  end
               end else begin
                  sp_ff <= sp_ff - 7'd1;
                  if (sp_ff > 7'd1) begin
                     if (low_v > disc_u) begin
                        if (u_rd < v_rd) mark_mem[u_rd][v_rd] <= 1'b1;
                        else mark_mem[v_rd][u_rd] <= 1'b1;
                     end
                     if (low_v < low_u) low_mem[u_rd] <= low_v;
                     state_ff <= S_READ;
                  end else begin
                     root_ff <= root_ff + 7'd1;
                     state_ff <= S_ROOT;
                  end
               end
            end
            S_BACK: begin
               if (par_v != x_ff && disc_x < low_v) low_mem[v_rd] <= disc_x;
               state_ff <= S_READ;
            end
            S_COUNT: begin
               if (row_ff == 7'(NV + 1)) begin
                  row_ff <= '0;
                  k_ff <= '0;
                  scan_ff <= '0;
                  state_ff <= (total_ff == '0) ? S_NONE : S_SCAN;
               end else begin
                  mrow_rd <= mark_mem[row_ff[VW-1:0]];
                  total_ff <= (7'(total_ff) + 7'($countones(mrow_rd)) > 7'd63)
                     ? 6'd63 : 6'(7'(total_ff) + 7'($countones(mrow_rd)));
                  row_ff <= row_ff + 7'd1;
               end
            end
            S_SCAN: begin
               if (k_ff == total_ff || row_ff == 7'(NV)) begin
                  row_ff <= '0;
                  state_ff <= S_CLEAR;
               end else begin
                  scan_ff <= mark_mem[row_ff[VW-1:0]];
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!many || k_ff == total_ff) begin
                  row_ff <= row_ff + 7'd1;
                  state_ff <= S_SCAN;
               end else if (out_load) begin
                  out_ff.has_bridge <= 1'b1;
                  out_ff.bridge_low <= row_ff[VW-1:0];
                  out_ff.bridge_high <= mfirst;
                  out_ff.bridge_total <= total_ff;
                  out_ff.last <= (k_ff + 6'd1 == total_ff);
                  k_ff <= k_ff + 6'd1;
                  scan_ff[mfirst] <= 1'b0;
               end
            end
            S_NONE: begin
               if (out_load) begin
                  out_ff <= '{has_bridge: 1'b0, bridge_low: '0, bridge_high: '0,
                              bridge_total: '0, last: 1'b1};
                  row_ff <= '0;
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               adj_mem[row_ff[VW-1:0]] <= '0;
               mark_mem[row_ff[VW-1:0]] <= '0;
               par_mem[row_ff[VW-1:0]] <= '0;
               vis_ff <= '0;
               row_ff <= row_ff + 7'd1;
               if (row_ff == 7'(NV - 1)) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
